/* hdl/msst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package msst_pkg;

  localparam int MAX_HITS   = 16;
  localparam int HIT_IDX_W  = 4;
  localparam int HIT_CNT_W  = 5;
  localparam int SLOT_W     = 4;
  localparam int COUNT_W    = 5;
  localparam int FIELD_W    = 32;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_STOP  = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef struct packed {
    logic apply;
    logic walk_begin;
    logic walk;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_free;
    logic emit_last;
  } status_t;

endpackage
`default_nettype wire

/* hdl/msst_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module msst_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire msst_pkg::func_t  func,
  input  wire msst_pkg::status_t sts,
  output msst_pkg::cmd_t        cmd
);
  import msst_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (func == FUNC_TICK) begin
            cmd.walk_begin = 1'b1;
            state_next     = ST_WALK;
          end else begin
            cmd.apply  = 1'b1;
            state_next = ST_EMIT;
          end
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/msst_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module msst_dp #(
  parameter int SLOTS      = 16,
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire msst_pkg::cmd_t               cmd,
  output msst_pkg::status_t                 sts,
  input  wire msst_pkg::func_t              in_func,
  input  wire logic [msst_pkg::SLOT_W-1:0]  in_slot,
  input  wire logic [msst_pkg::FIELD_W-1:0] in_interval,
  input  wire logic                         in_periodic,
  input  wire logic [msst_pkg::FIELD_W-1:0] in_elapsed,
  input  wire logic                         out_ready,
  output logic                              out_vld,
  output logic                              out_fired,
  output logic [msst_pkg::SLOT_W-1:0]       out_slot,
  output logic [msst_pkg::COUNT_W-1:0]      out_count,
  output logic                              out_accepted,
  output logic                              out_last
);
  import msst_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  logic [TIME_WIDTH-1:0] rem_mem [SLOTS];
  logic [TIME_WIDTH-1:0] rel_mem [SLOTS];

  logic [SLOTS-1:0]      running;
  logic [SLOTS-1:0]      periodic;
  logic [CNT_W-1:0]      total;
  logic                  acc_q;
  logic [TIME_WIDTH-1:0] elapsed_q;
  logic [CNT_W-1:0]      rd_cnt;
  logic                  p_vld;
  logic [IDX_W-1:0]      p_idx;
  logic [TIME_WIDTH-1:0] rem_q;
  logic [TIME_WIDTH-1:0] rel_q;
  logic [SLOT_W-1:0]     hits [MAX_HITS];
  logic [HIT_CNT_W-1:0]  hit_cnt;
  logic [HIT_CNT_W-1:0]  emit_cnt;

  logic [IDX_W+SLOT_W-1:0]      slot_wide;
  logic                         slot_ok;
  logic [IDX_W-1:0]             slot_idx;
  logic [TIME_WIDTH+FIELD_W-1:0] iv_wide;
  logic [TIME_WIDTH+FIELD_W-1:0] el_wide;
  logic [TIME_WIDTH-1:0]        iv;
  logic [TIME_WIDTH-1:0]        el;
  logic                         start_ok;
  logic                         stop_ok;
  logic                         rd_en;
  logic                         p_run;
  logic                         hit;
  logic [IDX_W+SLOT_W-1:0]      p_idx_wide;
  logic [CNT_W+COUNT_W-1:0]     total_wide;
  logic                         wr_en;
  logic                         wr_rel;
  logic [IDX_W-1:0]             wr_addr;
  logic [TIME_WIDTH-1:0]        wr_rem;

  assign slot_wide  = {{IDX_W{1'b0}}, in_slot};
  assign slot_ok    = slot_wide < (IDX_W + SLOT_W)'(SLOTS);
  assign slot_idx   = slot_wide[IDX_W-1:0];
  assign iv_wide    = {{TIME_WIDTH{1'b0}}, in_interval};
  assign el_wide    = {{TIME_WIDTH{1'b0}}, in_elapsed};
  assign iv         = iv_wide[TIME_WIDTH-1:0];
  assign el         = el_wide[TIME_WIDTH-1:0];
  assign start_ok   = slot_ok && (iv != '0);
  assign stop_ok    = slot_ok && running[slot_idx];
  assign rd_en      = cmd.walk && (rd_cnt != CNT_W'(SLOTS));
  assign p_run      = p_vld && running[p_idx];
  assign hit        = p_run && (elapsed_q >= rem_q);
  assign p_idx_wide = {{SLOT_W{1'b0}}, p_idx};
  assign total_wide = {{COUNT_W{1'b0}}, total};

  assign sts.walk_done = (rd_cnt == CNT_W'(SLOTS)) && !p_vld;
  assign sts.out_free  = !out_vld || out_ready;
  assign sts.emit_last = (hit_cnt == '0) || (emit_cnt == hit_cnt - HIT_CNT_W'(1));

  always_comb begin
    wr_en   = 1'b0;
    wr_rel  = 1'b0;
    wr_addr = p_idx;
    wr_rem  = rem_q - elapsed_q;
    if (cmd.apply && (in_func == FUNC_START) && start_ok) begin
      wr_en   = 1'b1;
      wr_rel  = 1'b1;
      wr_addr = slot_idx;
      wr_rem  = iv;
    end else if (p_run) begin
      if (!hit) begin
        wr_en = 1'b1;
      end else if (periodic[p_idx]) begin
        wr_en  = 1'b1;
        wr_rem = rel_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rem_mem[wr_addr] <= wr_rem;
    end
    if (wr_rel) begin
      rel_mem[wr_addr] <= iv;
    end
    if (rd_en) begin
      rem_q <= rem_mem[rd_cnt[IDX_W-1:0]];
      rel_q <= rel_mem[rd_cnt[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_begin) begin
      elapsed_q <= el;
    end
    if (hit && (hit_cnt != HIT_CNT_W'(MAX_HITS))) begin
      hits[hit_cnt[HIT_IDX_W-1:0]] <= p_idx_wide[SLOT_W-1:0];
    end
    if (rd_en) begin
      p_idx <= rd_cnt[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= '0;
      periodic <= '0;
      total    <= '0;
      acc_q    <= 1'b0;
      rd_cnt   <= '0;
      p_vld    <= 1'b0;
      hit_cnt  <= '0;
      emit_cnt <= '0;
    end else begin
      if (cmd.apply) begin
        hit_cnt  <= '0;
        emit_cnt <= '0;
        case (in_func)
          FUNC_START: begin
            acc_q <= start_ok;
            if (start_ok) begin
              running[slot_idx]  <= 1'b1;
              periodic[slot_idx] <= in_periodic;
              if (!running[slot_idx]) begin
                total <= total + CNT_W'(1);
              end
            end
          end
          FUNC_STOP: begin
            acc_q <= stop_ok;
            if (stop_ok) begin
              running[slot_idx] <= 1'b0;
              total             <= total - CNT_W'(1);
            end
          end
          FUNC_CLEAR: begin
            acc_q   <= 1'b1;
            running <= '0;
            total   <= '0;
          end
          default: begin
            acc_q <= 1'b1;
          end
        endcase
      end
      if (cmd.walk_begin) begin
        rd_cnt   <= '0;
        p_vld    <= 1'b0;
        hit_cnt  <= '0;
        emit_cnt <= '0;
        acc_q    <= 1'b1;
      end
      if (cmd.walk) begin
        p_vld <= rd_en;
        if (rd_en) begin
          rd_cnt <= rd_cnt + CNT_W'(1);
        end
      end
      if (hit) begin
        if (hit_cnt != HIT_CNT_W'(MAX_HITS)) begin
          hit_cnt <= hit_cnt + HIT_CNT_W'(1);
        end
        if (!periodic[p_idx]) begin
          running[p_idx] <= 1'b0;
          total          <= total - CNT_W'(1);
        end
      end
      if (cmd.emit) begin
        emit_cnt <= emit_cnt + HIT_CNT_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (cmd.emit) begin
      out_vld <= 1'b1;
    end else if (out_ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_fired    <= (hit_cnt != '0);
      out_slot     <= (hit_cnt != '0) ? hits[emit_cnt[HIT_IDX_W-1:0]] : '0;
      out_count    <= total_wide[COUNT_W-1:0];
      out_accepted <= acc_q;
      out_last     <= sts.emit_last;
    end
  end

endmodule
`default_nettype wire

/* hdl/multi_slot_software_timer.sv */
`timescale 1ns / 1ps
`default_nettype none
// Bank of SLOTS software timer slots (start, stop, tick, clear on s_tuser). Start, stop
// and clear give one result item. A tick walks every slot through the remaining-time
// and reload memories, one slot per cycle over their read ports, then gives its
// result items, each held while the output register is full: one item per expired
// slot in index order (at most 16 are reported, all take effect), or a single item
// when none expired. Every result carries the running count after the whole
// operation. A new item is taken once the last result of the previous one sits in
// the output register.
module multi_slot_software_timer #(
  parameter int SLOTS      = 16,
  parameter int TIME_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,  // slot[3:0], interval[35:4], periodic[36], elapsed[68:37]
  input  wire logic [1:0]  s_tuser,  // func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,  // fired_slot[3:0], active_count[8:4], accepted[9]
  output logic             m_tuser,  // fired
  output logic             m_tlast
);
  import msst_pkg::*;

  cmd_t                 cmd;
  status_t              sts;
  func_t                func;
  logic [SLOT_W-1:0]    fired_slot;
  logic [COUNT_W-1:0]   active_count;
  logic                 accepted;

  assign func = func_t'(s_tuser);

  msst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .func     (func),
    .sts      (sts),
    .cmd      (cmd)
  );

  msst_dp #(
    .SLOTS      (SLOTS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_func      (func),
    .in_slot      (s_tdata[3:0]),
    .in_interval  (s_tdata[35:4]),
    .in_periodic  (s_tdata[36]),
    .in_elapsed   (s_tdata[68:37]),
    .out_ready    (m_tready),
    .out_vld      (m_tvalid),
    .out_fired    (m_tuser),
    .out_slot     (fired_slot),
    .out_count    (active_count),
    .out_accepted (accepted),
    .out_last     (m_tlast)
  );

  assign m_tdata = {6'b0, accepted, active_count, fired_slot};

  a_fired_accepted: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[9])
    else $error("fired item not marked accepted");

  a_not_last_is_fired: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser)
    else $error("non-final item without an expiry");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.apply, cmd.walk_begin, cmd.walk, cmd.emit}))
    else $error("overlapping datapath commands");

  a_start_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.apply || cmd.walk_begin |-> s_tvalid && s_tready)
    else $error("operation started without an accepted item");

endmodule
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import msst_pkg::*;

  localparam int SLOTS = 16;

  typedef struct packed {
    func_t       func;
    logic [3:0]  slot;
    logic [31:0] interval;
    logic        periodic;
    logic [31:0] elapsed;
  } timer_cmd_t;

  typedef struct packed {
    logic       fired;
    logic [3:0] fired_slot;
    logic [4:0] active_count;
    logic       accepted;
    logic       last;
  } timer_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [1:0]  s_tuser = FUNC_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  multi_slot_software_timer #(
    .SLOTS(SLOTS),
    .TIME_WIDTH(32)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  timer_cmd_t    pending_cmds[$];
  timer_report_t expected_reports[$];

  // timer bank as the block should hold it
  logic [31:0]      left_ms[SLOTS];
  logic [31:0]      reload_ms[SLOTS];
  logic [SLOTS-1:0] periodic_mask = '0;
  logic [SLOTS-1:0] running_mask = '0;
  logic [4:0]       running_slots = '0;

  int   mismatches = 0;
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int   in_gap = 0;
  int   in_calm = 0;
  int   out_stall = 0;
  int   out_calm = 0;

  initial begin
    for (int k = 0; k < SLOTS; k++) begin
      left_ms[k] = '0;
      reload_ms[k] = '0;
    end
  end

  task automatic add_cmd(input func_t f, input logic [3:0] s, input logic [31:0] iv,
                         input logic p, input logic [31:0] el);
    timer_cmd_t c;
    c.func = f;
    c.slot = s;
    c.interval = iv;
    c.periodic = p;
    c.elapsed = el;
    pending_cmds.push_back(c);
  endtask

  function automatic timer_cmd_t random_cmd();
    timer_cmd_t  c;
    int unsigned pick;
    int unsigned shape;
    c.slot = 4'($urandom_range(0, 15));
    c.periodic = 1'($urandom_range(0, 1));
    c.interval = $urandom;
    c.elapsed = $urandom;
    pick = $urandom_range(0, 99);
    shape = $urandom_range(0, 9);
    if (pick < 42) begin
      c.func = FUNC_START;
      if (shape == 0) c.interval = '0;
      else if (shape == 1) c.interval = 32'hFFFF_FFFF - $urandom_range(0, 3);
      else if (shape < 4) c.interval = $urandom_range(1, 400);
      else c.interval = $urandom_range(1, 60);
    end else if (pick < 57) begin
      c.func = FUNC_STOP;
    end else if (pick < 96) begin
      c.func = FUNC_TICK;
      if (shape == 0) c.elapsed = '0;
      else if (shape == 1) c.elapsed = $urandom;
      else if (shape == 2) c.elapsed = 32'hFFFF_FFFF;
      else c.elapsed = $urandom_range(1, 24);
    end else begin
      c.func = FUNC_CLEAR;
    end
    return c;
  endfunction

  // random per-item wait, with runs of items that do not wait
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  task automatic advance_timer_bank(input timer_cmd_t c);
    logic [3:0]    hits[$];
    logic          ok;
    timer_report_t r;
    int            i;
    ok = 1'b1;
    case (c.func)
      FUNC_START: begin
        if (c.interval == '0) begin
          ok = 1'b0;
        end else begin
          reload_ms[c.slot] = c.interval;
          left_ms[c.slot] = c.interval;
          periodic_mask[c.slot] = c.periodic;
          if (!running_mask[c.slot]) begin
            running_mask[c.slot] = 1'b1;
            running_slots++;
          end
        end
      end
      FUNC_STOP: begin
        if (!running_mask[c.slot]) begin
          ok = 1'b0;
        end else begin
          running_mask[c.slot] = 1'b0;
          running_slots--;
        end
      end
      FUNC_TICK: begin
        for (i = 0; i < SLOTS; i++) begin
          if (running_mask[i]) begin
            if (c.elapsed >= left_ms[i]) begin
              if (hits.size() < MAX_HITS) hits.push_back(4'(i));
              if (periodic_mask[i]) begin
                left_ms[i] = reload_ms[i];
              end else begin
                running_mask[i] = 1'b0;
                running_slots--;
              end
            end else begin
              left_ms[i] = left_ms[i] - c.elapsed;
            end
          end
        end
      end
      default: begin
        running_mask = '0;
        running_slots = '0;
      end
    endcase
    if (hits.size() == 0) begin
      r = '{fired: 1'b0, fired_slot: 4'd0, active_count: running_slots, accepted: ok,
            last: 1'b1};
      expected_reports.push_back(r);
    end else begin
      for (i = 0; i < hits.size(); i++) begin
        r = '{fired: 1'b1, fired_slot: hits[i], active_count: running_slots, accepted: 1'b1,
              last: (i == hits.size() - 1)};
        expected_reports.push_back(r);
      end
    end
  endtask

  always @(negedge clk) begin : driver
    logic       next_valid;
    timer_cmd_t c;
    if (!rst) begin
      next_valid = s_tvalid && !in_fire;
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_cmds.size() > 0) begin
          c = pending_cmds.pop_front();
          s_tdata <= {3'b000, c.elapsed, c.periodic, c.interval, c.slot};
          s_tuser <= c.func;
          next_valid = 1'b1;
          in_gap = draw_wait(in_calm);
        end
      end
      s_tvalid <= next_valid;
    end
  end

  always @(negedge clk) begin : sink
    if (out_fire) out_stall = draw_wait(out_calm);
    if (out_stall > 0) begin
      m_tready <= 1'b0;
      out_stall--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    timer_cmd_t    c;
    timer_report_t want;
    timer_report_t got;
    if (rst) begin
      in_fire <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire <= s_tvalid && s_tready;
      out_fire <= m_tvalid && m_tready;
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata[3:0], m_tdata[8:4], m_tdata[9], m_tlast};
        if (expected_reports.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: fired %0d slot %0d count %0d accepted %0d last %0d",
                     got.fired, got.fired_slot, got.active_count, got.accepted, got.last);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display({"mismatch: expected fired %0d slot %0d count %0d accepted %0d ",
                        "last %0d, got fired %0d slot %0d count %0d accepted %0d last %0d"},
                       want.fired, want.fired_slot, want.active_count, want.accepted,
                       want.last, got.fired, got.fired_slot, got.active_count,
                       got.accepted, got.last);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        c.func = func_t'(s_tuser);
        c.slot = s_tdata[3:0];
        c.interval = s_tdata[35:4];
        c.periodic = s_tdata[36];
        c.elapsed = s_tdata[68:37];
        advance_timer_bank(c);
      end
    end
  end

  initial begin : stimulus
    int i;
    // empty bank, idle stop, zero interval
    add_cmd(FUNC_TICK, 4'd0, 32'd0, 1'b0, 32'd0);
    add_cmd(FUNC_STOP, 4'd9, 32'd5, 1'b1, 32'd0);
    add_cmd(FUNC_START, 4'd2, 32'd0, 1'b1, 32'hFFFF_FFFF);
    // arm every slot, odd ones periodic, top slot at the largest interval
    for (i = 0; i < SLOTS; i++)
      add_cmd(FUNC_START, 4'(i), (i == SLOTS - 1) ? 32'hFFFF_FFFF : 32'(i + 1), 1'(i), 32'd0);
    // restart of a running slot
    add_cmd(FUNC_START, 4'd4, 32'd100, 1'b0, 32'd0);
    // every slot expires at once
    add_cmd(FUNC_TICK, 4'd0, 32'd0, 1'b0, 32'hFFFF_FFFF);
    add_cmd(FUNC_STOP, 4'd3, 32'd0, 1'b0, 32'd0);
    add_cmd(FUNC_TICK, 4'd15, 32'hFFFF_FFFF, 1'b1, 32'd1);
    add_cmd(FUNC_CLEAR, 4'd0, 32'd0, 1'b0, 32'd0);
    add_cmd(FUNC_STOP, 4'd1, 32'd0, 1'b0, 32'd0);

    while (pending_cmds.size() < 410) begin
      if ($urandom_range(0, 24) == 0) begin
        // arm most slots with short intervals, then a long tick
        for (i = 0; i < SLOTS; i++)
          if ($urandom_range(0, 3) != 0)
            add_cmd(FUNC_START, 4'(i), $urandom_range(1, 8), 1'($urandom_range(0, 1)),
                    $urandom);
        add_cmd(FUNC_TICK, 4'($urandom_range(0, 15)), $urandom, 1'($urandom_range(0, 1)),
                $urandom_range(8, 20));
      end else begin
        pending_cmds.push_back(random_cmd());
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (pending_cmds.size() == 0);
    @(posedge clk);
    wait (!s_tvalid);
    wait (expected_reports.size() == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("multi_slot_software_timer test passed");
    end else begin
      $display("multi_slot_software_timer test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("multi_slot_software_timer test failed");
    $finish;
  end

endmodule
